/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Consequence holds in the same cycle as the condition
`define ASSERT_SAME(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Consequence holds in the cycle after the condition
`define ASSERT_NEXT(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define ASSERT_SAME(lbl, clk, rst, cond, cons)
`define ASSERT_NEXT(lbl, clk, rst, cond, cons)

`endif

`endif

/* rtl/ttc_pkg.sv */
package ttc_pkg;

  // Field and register widths
  localparam int LEN_W    = 16;
  localparam int PERIOD_W = LEN_W + 1;
  localparam int REP_W    = 4;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LEN_W;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_OFF      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STEADY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RINGBACK = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BUSY     = 2'd3;

  // Operation codes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RB_ON    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RB_OFF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUSY_ON  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUSY_OFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BUSY_REP = 3'd4;

  // Register reset values
  localparam logic [LEN_W-1:0] RB_ON_RST    = 16'd1500;
  localparam logic [LEN_W-1:0] RB_OFF_RST   = 16'd1000;
  localparam logic [LEN_W-1:0] BUSY_ON_RST  = 16'd1000;
  localparam logic [LEN_W-1:0] BUSY_OFF_RST = 16'd500;
  localparam logic [REP_W-1:0] BUSY_REP_RST = 4'd3;

  typedef struct packed {
    logic [LEN_W-1:0] ringback_on_len;
    logic [LEN_W-1:0] ringback_off_len;
    logic [LEN_W-1:0] busy_on_len;
    logic [LEN_W-1:0] busy_off_len;
    logic [REP_W-1:0] busy_repeats;
  } cfg_t;

  typedef struct packed {
    logic              tone_on;
    logic [MODE_W-1:0] mode_now;
  } result_t;

endpackage

/* rtl/ttc_cmd_if.sv */
interface ttc_cmd_if;
  import ttc_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [MODE_W-1:0] new_mode;

  modport source (output valid, output op, output new_mode, input ready);
  modport sink   (input valid, input op, input new_mode, output ready);
endinterface

/* rtl/ttc_res_if.sv */
interface ttc_res_if;
  import ttc_pkg::*;

  logic              valid;
  logic              ready;
  logic              tone_on;
  logic [MODE_W-1:0] mode_now;

  modport source (output valid, output tone_on, output mode_now, input ready);
  modport sink   (input valid, input tone_on, input mode_now, output ready);
endinterface

/* rtl/telephone_tone_cadence_top.sv */
// Channel  Dir  Beat fields
// cmd      in   op, new_mode
// res      out  tone_on, mode_now
// cfg_*    in   cfg_we, cfg_index, cfg_data (write only)
//
// One command beat per cycle unless stalled; result in the cycle after.
// Throughput is set by the single output register: cmd.ready stays high
// while the result register is empty or being drained in the same cycle.
// Synchronous reset clears mode, cadence position, burst count and the
// output valid flag and restores the register defaults.
`include "assert_macros.svh"

module telephone_tone_cadence_top
  import ttc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  ttc_cmd_if.sink               cmd,
  ttc_res_if.source             res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  result_t res_next;
  result_t res_q;
  logic    res_valid;
  logic    cmd_fire;

  assign cmd.ready = !res_valid || res.ready;
  assign cmd_fire  = cmd.valid && cmd.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ringback_on_len  <= RB_ON_RST;
      cfg.ringback_off_len <= RB_OFF_RST;
      cfg.busy_on_len      <= BUSY_ON_RST;
      cfg.busy_off_len     <= BUSY_OFF_RST;
      cfg.busy_repeats     <= BUSY_REP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RB_ON:    cfg.ringback_on_len  <= cfg_data;
        REG_RB_OFF:   cfg.ringback_off_len <= cfg_data;
        REG_BUSY_ON:  cfg.busy_on_len      <= cfg_data;
        REG_BUSY_OFF: cfg.busy_off_len     <= cfg_data;
        REG_BUSY_REP: cfg.busy_repeats     <= cfg_data[REP_W-1:0];
        default: ;
      endcase
    end
  end

  ttc_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .step     (cmd_fire),
    .op       (cmd.op),
    .new_mode (cmd.new_mode),
    .cfg      (cfg),
    .res      (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_fire) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      res_q <= res_next;
    end
  end

  assign res.valid    = res_valid;
  assign res.tone_on  = res_q.tone_on;
  assign res.mode_now = res_q.mode_now;

  // Checks
  `ASSERT_NEXT(a_fire_gives_beat, clk, rst, cmd_fire, res.valid)
  `ASSERT_SAME(a_stall_only_when_full, clk, rst, !cmd.ready, res.valid && !res.ready)
  `ASSERT_SAME(a_off_is_silent, clk, rst, res.valid && res.mode_now == MODE_OFF, !res.tone_on)
  `ASSERT_SAME(a_busy_needs_repeats, clk, rst, res.valid && res.mode_now == MODE_BUSY, cfg.busy_repeats != '0)

endmodule

/* rtl/ttc_engine.sv */
module ttc_engine
  import ttc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              op,
  input  logic [MODE_W-1:0] new_mode,
  input  cfg_t              cfg,
  output result_t           res
);

  logic [MODE_W-1:0]   cur_mode, cur_mode_next;
  logic [PERIOD_W-1:0] period_pos, period_pos_next;
  logic [REP_W-1:0]    bursts_done, bursts_done_next;

  logic [PERIOD_W-1:0] rb_period, busy_period, period;
  logic [PERIOD_W:0]   pos_inc;

  // Cadence periods, 17 bits so the sum never wraps
  assign rb_period   = {1'b0, cfg.ringback_on_len} + {1'b0, cfg.ringback_off_len};
  assign busy_period = {1'b0, cfg.busy_on_len} + {1'b0, cfg.busy_off_len};
  assign period      = (cur_mode == MODE_BUSY) ? busy_period : rb_period;
  assign pos_inc     = {1'b0, period_pos} + {{PERIOD_W{1'b0}}, 1'b1};

  // Next state for one beat
  always_comb begin
    cur_mode_next    = cur_mode;
    period_pos_next  = period_pos;
    bursts_done_next = bursts_done;

    if (op == OP_REQUEST) begin
      if (new_mode != cur_mode) begin
        cur_mode_next    = new_mode;
        period_pos_next  = '0;
        bursts_done_next = '0;
      end
    end else if (cur_mode == MODE_RINGBACK || cur_mode == MODE_BUSY) begin
      if (period == '0) begin
        period_pos_next = '0;
      end else if (pos_inc >= {1'b0, period}) begin
        period_pos_next = '0;
        if (cur_mode == MODE_BUSY) begin
          bursts_done_next = bursts_done + 1'b1;
        end
      end else begin
        period_pos_next = pos_inc[PERIOD_W-1:0];
      end
    end

    // Busy cadence runs out and falls back to off
    if (cur_mode_next == MODE_BUSY && bursts_done_next >= cfg.busy_repeats) begin
      cur_mode_next    = MODE_OFF;
      period_pos_next  = '0;
      bursts_done_next = '0;
    end
  end

  // Tone level from the updated state
  always_comb begin
    res.mode_now = cur_mode_next;
    case (cur_mode_next)
      MODE_STEADY:   res.tone_on = 1'b1;
      MODE_RINGBACK: res.tone_on = (period_pos_next <= {1'b0, cfg.ringback_on_len});
      MODE_BUSY:     res.tone_on = (period_pos_next <= {1'b0, cfg.busy_on_len});
      default:       res.tone_on = 1'b0;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode    <= MODE_OFF;
      period_pos  <= '0;
      bursts_done <= '0;
    end else if (step) begin
      cur_mode    <= cur_mode_next;
      period_pos  <= period_pos_next;
      bursts_done <= bursts_done_next;
    end
  end

endmodule

/* tb/telephone_tone_cadence_top_test.sv */
module telephone_tone_cadence_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ttc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_AT_BEAT = 600;
  localparam int HOLD_CYCLES = 60;
  localparam int SCRIPT_ROWS = 39;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  // One directed step: a command beat (optionally with a typed result) or a register write
  typedef struct packed {
    row_kind_t             kind;
    logic                  op;
    logic [MODE_W-1:0]     mode;
    logic                  pinned;
    result_t               want;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } script_row_t;

  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // default registers: steady, repeated request, ringback, busy, back to off
    '{ROW_BEAT, OP_TICK,    MODE_OFF,      1'b1, '{1'b0, MODE_OFF},      '0, '0},
    '{ROW_BEAT, OP_REQUEST, MODE_STEADY,   1'b1, '{1'b1, MODE_STEADY},   '0, '0},
    '{ROW_BEAT, OP_TICK,    MODE_RINGBACK, 1'b1, '{1'b1, MODE_STEADY},   '0, '0},
    '{ROW_BEAT, OP_REQUEST, MODE_STEADY,   1'b1, '{1'b1, MODE_STEADY},   '0, '0},
    '{ROW_BEAT, OP_REQUEST, MODE_RINGBACK, 1'b1, '{1'b1, MODE_RINGBACK}, '0, '0},
    '{ROW_BEAT, OP_TICK,    MODE_BUSY,     1'b0, '{1'b0, MODE_OFF},      '0, '0},
    '{ROW_BEAT, OP_REQUEST, MODE_BUSY,     1'b1, '{1'b1, MODE_BUSY},     '0, '0},
    '{ROW_BEAT, OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      '0, '0},
    '{ROW_BEAT, OP_REQUEST, MODE_OFF,      1'b1, '{1'b0, MODE_OFF},      '0, '0},
    // zero ringback period, short busy cadence that runs out after two bursts
    '{ROW_CFG,  OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      REG_RB_ON,    16'd0},
    '{ROW_CFG,  OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      REG_RB_OFF,   16'd0},
    '{ROW_CFG,  OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      REG_BUSY_ON,  16'd1},
    '{ROW_CFG,  OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      REG_BUSY_OFF, 16'd1},
    '{ROW_CFG,  OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      REG_BUSY_REP, 16'd2},
    '{ROW_BEAT, OP_REQUEST, MODE_RINGBACK, 1'b1, '{1'b1, MODE_RINGBACK}, '0, '0},
    '{ROW_BEAT, OP_TICK,    MODE_OFF,      1'b1, '{1'b1, MODE_RINGBACK}, '0, '0},
    '{ROW_BEAT, OP_REQUEST, MODE_BUSY,     1'b1, '{1'b1, MODE_BUSY},     '0, '0},
    '{ROW_BEAT, OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      '0, '0},
    '{ROW_BEAT, OP_TICK,    MODE_STEADY,   1'b0, '{1'b0, MODE_OFF},      '0, '0},
    '{ROW_BEAT, OP_TICK,    MODE_RINGBACK, 1'b0, '{1'b0, MODE_OFF},      '0, '0},
    '{ROW_BEAT, OP_TICK,    MODE_BUSY,     1'b0, '{1'b0, MODE_OFF},      '0, '0},
    // no repeats: busy drops to off on the request itself
    '{ROW_CFG,  OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      REG_BUSY_REP, 16'd0},
    '{ROW_BEAT, OP_REQUEST, MODE_BUSY,     1'b1, '{1'b0, MODE_OFF},      '0, '0},
    // period shrinks under a position already past its end
    '{ROW_CFG,  OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      REG_RB_ON,    16'd1},
    '{ROW_CFG,  OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      REG_RB_OFF,   16'd5},
    '{ROW_BEAT, OP_REQUEST, MODE_RINGBACK, 1'b1, '{1'b1, MODE_RINGBACK}, '0, '0},
    '{ROW_BEAT, OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      '0, '0},
    '{ROW_BEAT, OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      '0, '0},
    '{ROW_BEAT, OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      '0, '0},
    '{ROW_BEAT, OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      '0, '0},
    '{ROW_CFG,  OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      REG_RB_OFF,   16'd2},
    '{ROW_BEAT, OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      '0, '0},
    // all registers at their maximum
    '{ROW_CFG,  OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      REG_RB_ON,    16'hFFFF},
    '{ROW_CFG,  OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      REG_RB_OFF,   16'hFFFF},
    '{ROW_CFG,  OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      REG_BUSY_ON,  16'hFFFF},
    '{ROW_CFG,  OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      REG_BUSY_OFF, 16'hFFFF},
    '{ROW_CFG,  OP_TICK,    MODE_OFF,      1'b0, '{1'b0, MODE_OFF},      REG_BUSY_REP, 16'hFFFF},
    '{ROW_BEAT, OP_TICK,    MODE_BUSY,     1'b0, '{1'b0, MODE_OFF},      '0, '0},
    '{ROW_BEAT, OP_REQUEST, MODE_BUSY,     1'b1, '{1'b1, MODE_BUSY},     '0, '0}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // typed result travelling with the current command beat
  logic pin_on;
  result_t pin_res;

  int idle_pct;
  int stall_pct;
  int beats_accepted = 0;
  int mismatches = 0;

  // cadence model state and its copy of the registers
  cfg_t cadence_cfg = '{RB_ON_RST, RB_OFF_RST, BUSY_ON_RST, BUSY_OFF_RST, BUSY_REP_RST};
  logic [MODE_W-1:0] tone_mode = MODE_OFF;
  logic [PERIOD_W-1:0] cadence_pos = '0;
  logic [REP_W-1:0] bursts_seen = '0;
  result_t pending_tones[$];

  ttc_cmd_if cmd_ch();
  ttc_res_if res_ch();

  telephone_tone_cadence_top u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Advance the cadence by one command and return the tone and mode after it
  function automatic result_t step_cadence(logic op, logic [MODE_W-1:0] req);
    logic [LEN_W-1:0] on_len;
    logic [LEN_W-1:0] off_len;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] nxt;
    result_t r;
    if (op == OP_REQUEST) begin
      if (req != tone_mode) begin
        tone_mode = req;
        cadence_pos = '0;
        bursts_seen = '0;
      end
    end else if (tone_mode == MODE_RINGBACK || tone_mode == MODE_BUSY) begin
      on_len = (tone_mode == MODE_BUSY) ? cadence_cfg.busy_on_len : cadence_cfg.ringback_on_len;
      off_len = (tone_mode == MODE_BUSY) ? cadence_cfg.busy_off_len
                                         : cadence_cfg.ringback_off_len;
      period = PERIOD_W'(on_len) + PERIOD_W'(off_len);
      if (period == '0) begin
        cadence_pos = '0;
      end else begin
        nxt = cadence_pos + 1'b1;
        if (nxt >= period) begin
          nxt = '0;
          if (tone_mode == MODE_BUSY) bursts_seen = bursts_seen + 1'b1;
        end
        cadence_pos = nxt;
      end
    end
    // busy runs out after the programmed number of bursts
    if (tone_mode == MODE_BUSY && bursts_seen >= cadence_cfg.busy_repeats) begin
      tone_mode = MODE_OFF;
      cadence_pos = '0;
      bursts_seen = '0;
    end
    r.mode_now = tone_mode;
    case (tone_mode)
      MODE_STEADY:   r.tone_on = 1'b1;
      MODE_RINGBACK: r.tone_on = (cadence_pos <= PERIOD_W'(cadence_cfg.ringback_on_len));
      MODE_BUSY:     r.tone_on = (cadence_pos <= PERIOD_W'(cadence_cfg.busy_on_len));
      default:       r.tone_on = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return LEN_W'($urandom_range(65535));
      default: return LEN_W'($urandom_range(1, 12));
    endcase
  endfunction

  // Offer one command beat and hold it until accepted
  task automatic offer_beat(logic op, logic [MODE_W-1:0] mode, logic pinned, result_t want);
    while ($urandom_range(99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.op <= op;
    cmd_ch.new_mode <= mode;
    pin_on <= pinned;
    pin_res <= want;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Stop offering and let every outstanding result drain
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_tones.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_RB_ON:    cadence_cfg.ringback_on_len = data;
      REG_RB_OFF:   cadence_cfg.ringback_off_len = data;
      REG_BUSY_ON:  cadence_cfg.busy_on_len = data;
      REG_BUSY_OFF: cadence_cfg.busy_off_len = data;
      REG_BUSY_REP: cadence_cfg.busy_repeats = data[REP_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result checking first, then prediction for the command accepted at this edge
  always @(posedge clk) begin : track_tones
    result_t want;
    result_t got;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_tones.size() == 0) begin
          $error("result beat with no command outstanding: tone_on %0d mode_now %0d",
                 res_ch.tone_on, res_ch.mode_now);
          mismatches++;
        end else begin
          want = pending_tones.pop_front();
          if (res_ch.tone_on !== want.tone_on) begin
            $error("tone_on: expected %0d, got %0d", want.tone_on, res_ch.tone_on);
            mismatches++;
          end
          if (res_ch.mode_now !== want.mode_now) begin
            $error("mode_now: expected %0d, got %0d", want.mode_now, res_ch.mode_now);
            mismatches++;
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        got = step_cadence(cmd_ch.op, cmd_ch.new_mode);
        pending_tones.push_back(pin_on ? pin_res : got);
        beats_accepted++;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off to back up the input
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && beats_accepted >= HOLD_AT_BEAT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: ends the run if no beat moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("telephone_tone_cadence_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    result_t none;
    logic [MODE_W-1:0] mode;
    none = '0;
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.op <= OP_TICK;
    cmd_ch.new_mode <= MODE_OFF;
    cfg_we <= 1'b0;
    cfg_index <= REG_RB_ON;
    cfg_data <= '0;
    pin_on <= 1'b0;
    pin_res <= '0;
    idle_pct = 7;
    stall_pct = 77;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(SCRIPT[i].reg_idx, SCRIPT[i].reg_val);
      end else begin
        offer_beat(SCRIPT[i].op, SCRIPT[i].mode, SCRIPT[i].pinned, SCRIPT[i].want);
      end
    end

    // random phases: new register set each phase, idling pattern every third
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph / 3)
        0: begin idle_pct = 7;  stall_pct = 77; end
        1: begin idle_pct = 77; stall_pct = 7;  end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      if (ph == 1) begin
        write_reg(REG_RB_ON, '1);
        write_reg(REG_RB_OFF, '1);
        write_reg(REG_BUSY_ON, '1);
        write_reg(REG_BUSY_OFF, '1);
        write_reg(REG_BUSY_REP, '1);
      end else if (ph == 2) begin
        write_reg(REG_RB_ON, '0);
        write_reg(REG_RB_OFF, '0);
        write_reg(REG_BUSY_ON, '0);
        write_reg(REG_BUSY_OFF, '0);
        write_reg(REG_BUSY_REP, '0);
      end else begin
        write_reg(REG_RB_ON, pick_len());
        write_reg(REG_RB_OFF, pick_len());
        write_reg(REG_BUSY_ON, pick_len());
        write_reg(REG_BUSY_OFF, pick_len());
        // upper bits are ignored by the block; exercise them now and then
        write_reg(REG_BUSY_REP, ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(65535))
                                                          : CFG_DATA_W'($urandom_range(1, 6)));
      end
      // mostly ticks so cadences wrap and busy runs out; requests now and then
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        mode = MODE_W'($urandom_range(3));
        if ($urandom_range(99) < 15) offer_beat(OP_REQUEST, mode, 1'b0, none);
        else offer_beat(OP_TICK, mode, 1'b0, none);
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("telephone_tone_cadence_top: match");
    else $display("telephone_tone_cadence_top: mismatch");
    $finish;
  end

endmodule
